### sv/bfrs_pkg.sv
// Shared types, codes and the per-byte run finder for the bitmap free-run search unit.
package bfrs_pkg;

  // Fixed widths of the transaction fields.
  localparam int OP_W    = 2;
  localparam int BIDX_W  = 12;
  localparam int BVAL_W  = 8;
  localparam int LEN_W   = 16;
  localparam int START_W = 15;
  localparam int CFG_W   = 16;
  // Byte pointer wide enough for any bit index below 2**16 plus one step past it.
  localparam int BP_W    = 14;
  // Cursor kept as a byte index; its bit index is always a multiple of eight.
  localparam int CUR_W   = START_W - 3;
  // Chain length and chain end widths.
  localparam int RC_W    = LEN_W + 1;
  localparam int END_W   = LEN_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_FIND  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_OUT
  } state_t;

  // First run of clear bits inside one byte.
  typedef struct packed {
    logic [2:0] start;
    logic [3:0] count;
  } byte_run_t;

  // Result of folding one map byte into the chained run.
  typedef struct packed {
    logic             stop;
    logic [LEN_W-1:0] rs;
    logic [RC_W-1:0]  rc;
  } chain_t;

  // Find the lowest clear bit and count the unbroken run of clear bits from there, up to bit 7 at most.
  function automatic byte_run_t first_free_run(input logic [7:0] b);
    byte_run_t r;
    logic      found;
    logic      alive;
    r.start = 3'd0;
    r.count = 4'd0;
    found   = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!found && !b[j]) begin
        found   = 1'b1;
        r.start = 3'(j);
      end
    end
    alive = found;
    for (int j = 0; j < 8; j++) begin
      if (3'(j) >= r.start) begin
        if (alive && !b[j]) begin
          r.count = r.count + 4'd1;
        end else begin
          alive = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

### sv/bfrs_map_mem.sv
// Byte-wide map storage with one write port and one registered read port.
module bfrs_map_mem
  import bfrs_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [BVAL_W-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [BVAL_W-1:0]                          rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BVAL_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     waddr_chk;

  assign waddr_chk = waddr;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr_chk] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

### sv/bfrs_chain.sv
// Folds one map byte into the chained free run and decides whether the pass stops.
module bfrs_chain
  import bfrs_pkg::*;
(
  input  logic [BVAL_W-1:0] byte_val,
  input  logic [RC_W-1:0]   bit_idx,
  input  logic [LEN_W-1:0]  rs,
  input  logic [RC_W-1:0]   rc,
  input  logic [LEN_W-1:0]  want,
  output chain_t            step
);

  byte_run_t        run;
  logic [END_W-1:0] s;
  logic [END_W-1:0] chain_end;
  logic [RC_W-1:0]  rc_sum;
  logic             brk;
  logic             hit;

  // Run inside this byte, and where it lands in the map.
  always_comb begin
    run       = first_free_run(byte_val);
    s         = END_W'(bit_idx) + END_W'(run.start);
    chain_end = END_W'(rs) + END_W'(rc);
  end

  // A chain breaks when the byte has no free bit or its run is not adjacent.
  always_comb begin
    brk    = (rc != '0) && ((run.count == 4'd0) || (s != chain_end));
    rc_sum = (rc == '0) ? RC_W'(run.count) : rc + RC_W'(run.count);
    hit    = !brk && (run.count != 4'd0) && (rc_sum >= RC_W'(want));
    step.stop = brk || hit;
    step.rs   = rs;
    step.rc   = rc;
    if (!brk && (run.count != 4'd0)) begin
      step.rc = rc_sum;
      if (rc == '0) begin
        step.rs = s[LEN_W-1:0];
      end
    end
  end

endmodule

### sv/bitmap_free_run_search_unit.sv
// Top level of the bitmap free-run search unit: control, cursor, clear sweep and output stage.
//
// The unit keeps a free-space bitmap of MAP_BYTES bytes in one synchronous memory and a
// next-fit cursor. A write transaction stores one map byte. A clear transaction sweeps the
// memory one byte per cycle and holds the input off until the sweep has written the last
// byte; afterwards the eight bits from map_bits upward read as used and all others as free.
// A find transaction reads one map byte per cycle from the cursor through the memory's single
// read port. A pass examines bytes up to and including the one that meets the map end, breaks
// the run or completes it. The result then waits in a holding register and moves to the
// output register once that is free. A find that comes up empty with a nonzero cursor runs
// a second pass from the start. A find with a zero search length skips the scan and reports
// start and length zero. One find gives one result transaction; the input is accepted only
// while no find, clear or pending result is in progress, and the result register lets a new
// transaction in while an earlier result waits to be taken. The map contents are undefined
// after reset until a clear or writes have covered the bytes that a find reads.
module bitmap_free_run_search_unit
  import bfrs_pkg::*;
#(
  parameter int MAP_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Fields from bit 0 up: operation[1:0], byte_index[13:2], byte_value[21:14],
  // search_length[37:22], zero fill[39:38].
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: run_start[14:0], run_length[30:15], zero fill[31].
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CAP_BITS = MAP_BYTES * 8;
  localparam logic [RC_W-1:0] CAP = (CAP_BITS > 65535) ? RC_W'(65536) : RC_W'(CAP_BITS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

  // Input field unpacking.
  logic [OP_W-1:0]   in_op;
  logic [BIDX_W-1:0] in_byte_index;
  logic [BVAL_W-1:0] in_byte_value;
  logic [LEN_W-1:0]  in_search_length;

  assign in_op            = in_tdata[1:0];
  assign in_byte_index    = in_tdata[13:2];
  assign in_byte_value    = in_tdata[21:14];
  assign in_search_length = in_tdata[37:22];

  // Registers.
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   map_bits_r;
  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic [BP_W-1:0]    iss_r, iss_nxt;
  logic [BP_W-1:0]    idx_d_r, idx_d_nxt;
  logic               dval_r, dval_nxt;
  logic [LEN_W-1:0]   rs_r, rs_nxt;
  logic [RC_W-1:0]    rc_r, rc_nxt;
  logic [LEN_W-1:0]   want_r, want_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [START_W-1:0] res_start_r, res_start_nxt;
  logic [LEN_W-1:0]   res_len_r, res_len_nxt;
  logic [START_W-1:0] out_start_r, out_start_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Memory port signals.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BVAL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BVAL_W-1:0] mem_rdata;

  // Scan helpers.
  logic [RC_W-1:0]   limit;
  logic [RC_W-1:0]   idx_d_bits;
  chain_t            step;
  logic [RC_W-1:0]   fin_rc;
  logic [LEN_W-1:0]  fin_rs;
  logic              pass_end;

  // Clear sweep helpers.
  logic [RC_W-1:0]   mark_b0;
  logic [RC_W-1:0]   clr_ext;
  logic [BVAL_W-1:0] mark_lo;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_start_r};

  // Scan bound: the configured size, capped at the storage size.
  assign limit      = ({1'b0, map_bits_r} < CAP) ? {1'b0, map_bits_r} : CAP;
  assign idx_d_bits = {idx_d_r, 3'b000};

  // Bytes that carry the used marks beyond the map end.
  assign mark_b0 = RC_W'(map_bits_r[CFG_W-1:3]);
  assign clr_ext = RC_W'(clr_r);
  assign mark_lo = 8'hFF << map_bits_r[2:0];

  bfrs_map_mem #(
    .DEPTH (MAP_BYTES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfrs_chain u_chain (
    .byte_val (mem_rdata),
    .bit_idx  (idx_d_bits),
    .rs       (rs_r),
    .rc       (rc_r),
    .want     (want_r),
    .step     (step)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_bits_r <= 16'd32768;
    end else if (cfg_we) begin
      map_bits_r <= cfg_wdata;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      dval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      dval_r      <= dval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    iss_r       <= iss_nxt;
    idx_d_r     <= idx_d_nxt;
    rs_r        <= rs_nxt;
    rc_r        <= rc_nxt;
    want_r      <= want_nxt;
    clr_r       <= clr_nxt;
    res_start_r <= res_start_nxt;
    res_len_r   <= res_len_nxt;
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    iss_nxt       = iss_r;
    idx_d_nxt     = idx_d_r;
    dval_nxt      = dval_r;
    rs_nxt        = rs_r;
    rc_nxt        = rc_r;
    want_nxt      = want_r;
    clr_nxt       = clr_r;
    res_start_nxt = res_start_r;
    res_len_nxt   = res_len_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(in_byte_index);
    mem_wdata     = in_byte_value;
    mem_raddr     = AW'(iss_r);
    fin_rc        = rc_r;
    fin_rs        = rs_r;
    pass_end      = 1'b0;

    // Result register drains on an output transaction.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_FIND: begin
              want_nxt = in_search_length;
              rs_nxt   = '0;
              rc_nxt   = '0;
              iss_nxt  = BP_W'(cur_r);
              dval_nxt = 1'b0;
              if (in_search_length == '0) begin
                res_start_nxt = '0;
                res_len_nxt   = '0;
                state_nxt     = ST_OUT;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_WRITE: begin
              mem_we = (32'(in_byte_index) < MAP_BYTES);
            end
            OP_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      ST_CLEAR: begin
        // Zero every byte, placing the used marks on the bytes past the map end.
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_ext == mark_b0) begin
          mem_wdata = mark_lo;
        end else if (clr_ext == mark_b0 + RC_W'(1)) begin
          mem_wdata = ~mark_lo;
        end else begin
          mem_wdata = '0;
        end
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Issue the next byte read while the previous byte is folded in.
        iss_nxt   = iss_r + BP_W'(1);
        idx_d_nxt = iss_r;
        dval_nxt  = 1'b1;
        if (dval_r) begin
          if (idx_d_bits >= limit) begin
            pass_end = 1'b1;
          end else begin
            rs_nxt = step.rs;
            rc_nxt = step.rc;
            fin_rs = step.rs;
            fin_rc = step.rc;
            if (step.stop) begin
              cur_nxt  = idx_d_r[CUR_W-1:0];
              pass_end = 1'b1;
            end
          end
        end
        if (pass_end) begin
          if ((fin_rc == '0) && (cur_r != '0)) begin
            // Nothing found past the cursor: rescan from the start of the map.
            cur_nxt  = '0;
            iss_nxt  = '0;
            dval_nxt = 1'b0;
            rs_nxt   = '0;
            rc_nxt   = '0;
          end else begin
            res_len_nxt   = (fin_rc > RC_W'(want_r)) ? want_r : fin_rc[LEN_W-1:0];
            res_start_nxt = (fin_rc == '0) ? '0 : fin_rs[START_W-1:0];
            dval_nxt      = 1'b0;
            state_nxt     = ST_OUT;
          end
        end
      end

      ST_OUT: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || out_tready) begin
          out_start_nxt = res_start_r;
          out_len_nxt   = res_len_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A reported run never exceeds the requested length.
  a_len_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (res_len_r <= want_r))
    else $error("run length exceeds the requested length");

  // An empty result always reports start zero.
  a_empty_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && res_len_r == '0) |-> (res_start_r == '0))
    else $error("empty run reported with a nonzero start");

  // The map is never written while a find is scanning it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("map write during a scan");

  // A clear sweep always ends back in idle after the last byte.
  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_r == LAST_ADDR) |=> (state_r == ST_IDLE))
    else $error("clear sweep did not finish at the last byte");

endmodule

### dv/tb_bitmap_free_run_search_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap free-run search unit with a mirrored free map.
module tb_bitmap_free_run_search_unit;
  import bfrs_pkg::*;

  localparam int MAP_BYTES        = 4096;
  localparam int MAP_BITS_MAX     = MAP_BYTES * 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES      = 400;
  // A clear sweeps every map byte, so this covers any work left in flight.
  localparam int SETTLE_CYCLES    = MAP_BYTES + 16;
  // Two full find passes, a clear and the long receiver hold fit well inside this.
  localparam int WATCHDOG_LIMIT   = 40000;
  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 85;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
  } free_run_t;

  // Mirror of the free map and cursor; predicts each find and checks the results in order.
  class free_map_mirror;
    bit [7:0]    map_store[MAP_BYTES];
    int unsigned cursor;
    int unsigned map_bits;
    free_run_t   pending_runs[$];
    int unsigned mismatches;

    function new();
      foreach (map_store[i]) map_store[i] = 8'h00;
      cursor     = 0;
      map_bits   = MAP_BITS_MAX;
      mismatches = 0;
    endfunction

    // Lowest clear bit of a byte and the unbroken run of clear bits from it, stopping at bit 7.
    function void lowest_free_run(input bit [7:0] b, output int unsigned lo,
                                  output int unsigned cnt);
      lo  = 0;
      cnt = 0;
      for (int j = 0; j < 8; j++) begin
        if (!b[j]) begin
          lo = j;
          while (j + cnt < 8 && !b[j + cnt]) cnt++;
          return;
        end
      end
    endfunction

    // One pass from the cursor, chaining runs while each begins where the last ended.
    function void scan_from_cursor(input int unsigned want, output int unsigned rs,
                                   output int unsigned rc);
      int unsigned bound;
      int unsigned idx;
      int unsigned s;
      int unsigned c;
      bound = (map_bits < MAP_BITS_MAX) ? map_bits : MAP_BITS_MAX;
      rs = 0;
      rc = 0;
      for (idx = cursor; idx < bound; idx += 8) begin
        lowest_free_run(map_store[(idx >> 3) % MAP_BYTES], s, c);
        s += idx;
        if (rc != 0 && (c == 0 || s != rs + rc)) begin
          cursor = idx & 32'h7FFF;
          return;
        end
        if (c != 0) begin
          if (rc == 0) begin
            rs = s;
            rc = c;
          end else begin
            rc += c;
          end
          if (rc >= want) begin
            cursor = idx & 32'h7FFF;
            return;
          end
        end
      end
    endfunction

    // Apply one accepted input transaction; a find queues its expected run.
    function void note_transaction(input logic [39:0] data);
      logic [OP_W-1:0]   op;
      logic [BIDX_W-1:0] byte_idx;
      logic [BVAL_W-1:0] value;
      int unsigned       want;
      int unsigned       rs;
      int unsigned       rc;
      int unsigned       mark;
      free_run_t         run;
      op       = data[1:0];
      byte_idx = data[13:2];
      value    = data[21:14];
      want     = 32'(data[37:22]);
      case (op)
        OP_WRITE: begin
          if (byte_idx < MAP_BYTES) map_store[byte_idx] = value;
        end
        OP_CLEAR: begin
          foreach (map_store[i]) map_store[i] = 8'h00;
          // The eight bits past the map end read as used; marks past the store drop.
          for (int i = 0; i < 8; i++) begin
            mark = map_bits + i;
            if ((mark >> 3) < MAP_BYTES) map_store[mark >> 3][mark & 7] = 1'b1;
          end
        end
        OP_FIND: begin
          rs = 0;
          rc = 0;
          if (want != 0) begin
            scan_from_cursor(want, rs, rc);
            // Nothing from the cursor onward: wrap to the start once.
            if (rc == 0 && cursor != 0) begin
              cursor = 0;
              scan_from_cursor(want, rs, rc);
            end
            if (rc > want) rc = want;
            if (rc == 0) rs = 0;
          end
          run.start  = START_W'(rs);
          run.length = LEN_W'(rc);
          pending_runs = {pending_runs, run};
        end
        default: begin
          // The unused code changes nothing.
        end
      endcase
    endfunction

    // Compare one accepted result transaction with the oldest expected run.
    function void check_run(input logic [31:0] data);
      free_run_t got;
      free_run_t want;
      got.start  = data[14:0];
      got.length = data[30:15];
      if (pending_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: unexpected result start=%0d length=%0d", got.start, got.length);
        end
        return;
      end
      want = pending_runs.pop_front();
      if (got.start !== want.start || got.length !== want.length) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: run start expected %0d got %0d, length expected %0d got %0d",
                   want.start, got.start, want.length, got.length);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;

  free_map_mirror mirror = new();
  bit             tx_steady    = 1'b0;
  bit             rx_steady    = 1'b0;
  bit             hold_off_req = 1'b0;
  int unsigned    stuck_cycles = 0;

  bitmap_free_run_search_unit #(
    .MAP_BYTES(MAP_BYTES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Monitor: feeds the mirror with every handshake and watches for a hung block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) mirror.note_transaction(in_tdata);
      if (out_tvalid && out_tready) mirror.check_run(out_tdata);
      if (cfg_we) mirror.map_bits = 32'(cfg_wdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold when asked for.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Offer one input transaction and wait until it is taken.
  task automatic send_transaction(input logic [OP_W-1:0] op,
                                  input logic [BIDX_W-1:0] byte_idx,
                                  input logic [BVAL_W-1:0] value,
                                  input logic [LEN_W-1:0] want);
    int unsigned gap;
    in_tdata  <= {2'b00, want, value, byte_idx, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every expected run, then let any clear sweep finish.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (mirror.pending_runs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_map_bits(input logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random transaction; writes mostly land inside the active part of the map.
  task automatic random_transaction(input int unsigned map_size, input bit find_only);
    int unsigned       roll;
    int unsigned       span;
    int unsigned       k;
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] byte_idx;
    logic [BVAL_W-1:0] value;
    logic [LEN_W-1:0]  want;
    roll = $urandom_range(0, 99);
    if (find_only || roll < 45) begin
      op = OP_FIND;
    end else if (roll < 93) begin
      op = OP_WRITE;
    end else if (roll < 96) begin
      op = OP_CLEAR;
    end else begin
      op = OP_UNUSED;
    end
    span = (map_size >> 3) + 1;
    if (span > MAP_BYTES - 1) span = MAP_BYTES - 1;
    if ($urandom_range(0, 4) == 0) begin
      byte_idx = BIDX_W'($urandom_range(0, MAP_BYTES - 1));
    end else begin
      byte_idx = BIDX_W'($urandom_range(0, span));
    end
    // Byte patterns that make runs at the bottom, at the top, or none at all.
    k    = $urandom_range(1, 7);
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      value = 8'h00;
    end else if (roll < 35) begin
      value = 8'hFF;
    end else if (roll < 50) begin
      value = 8'((1 << k) - 1);
    end else if (roll < 65) begin
      value = ~8'((1 << k) - 1);
    end else begin
      value = BVAL_W'($urandom_range(0, 255));
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      want = '0;
    end else if (roll < 15) begin
      want = LEN_W'($urandom_range(0, 65535));
    end else if (roll < 25) begin
      want = LEN_W'($urandom_range(1, map_size + 16));
    end else begin
      want = LEN_W'($urandom_range(1, 24));
    end
    send_transaction(op, byte_idx, value, want);
  endtask

  initial begin : stimulus
    int unsigned map_size;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Full-size map after reset: next-fit behavior, wrap, byte-edge runs.
    send_transaction(OP_CLEAR, BIDX_W'($urandom), BVAL_W'($urandom), LEN_W'($urandom));
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd1);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd0);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'hFFFF);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd32768);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd16);
    send_transaction(OP_WRITE, 12'hFFF, 8'hFF, 16'd0);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd4);
    send_transaction(OP_WRITE, 12'h000, 8'h0F, 16'd0);
    send_transaction(OP_WRITE, 12'h001, 8'h00, 16'd0);
    send_transaction(OP_WRITE, 12'h002, 8'hFF, 16'd0);
    send_transaction(OP_WRITE, 12'h003, 8'h7F, 16'd0);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd20);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd1);
    send_transaction(OP_WRITE, 12'hAAA, 8'h55, 16'hAAAA);
    send_transaction(OP_WRITE, 12'h555, 8'hAA, 16'h5555);
    send_transaction(OP_UNUSED, 12'hFFF, 8'hFF, 16'hFFFF);
    send_transaction(OP_FIND, 12'h000, 8'h81, 16'd9);

    // Empty map: no run, and the clear marks land in the first byte.
    set_map_bits(16'd0);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd5);
    send_transaction(OP_CLEAR, 12'h000, 8'h00, 16'd0);

    // Size past the store: scan capped at the store, end marks dropped.
    set_map_bits(16'hFFFF);
    send_transaction(OP_CLEAR, 12'h000, 8'h00, 16'd0);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'hFFFF);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd32768);

    // One-bit map with the cursor far past its end.
    set_map_bits(16'd1);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd3);
    send_transaction(OP_CLEAR, 12'h000, 8'h00, 16'd0);
    send_transaction(OP_FIND, 12'h000, 8'h00, 16'd3);

    // Random phases, mostly on small maps; one phase holds the result side off.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        3: map_size = MAP_BITS_MAX;
        7: map_size = $urandom_range(1, MAP_BITS_MAX);
        default: map_size = $urandom_range(1, 256);
      endcase
      set_map_bits(16'(map_size));
      tx_steady = (p == 1) || ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (p % 3 != 2) begin
        send_transaction(OP_CLEAR, BIDX_W'($urandom), BVAL_W'($urandom), LEN_W'($urandom));
      end
      if (p == 1) hold_off_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_transaction(map_size, p == 1 && n < 6);
      end
    end

    drain_results();
    if (mirror.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
